@@ src/thq_pkg.sv @@
// thq_pkg: shared types and constants of the terrain height query block
package thq_pkg;

  localparam int unsigned DEF_MAX_TRIANGLES = 1024;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned MUL_W    = 35;
  localparam int unsigned PROD_W   = 70;
  localparam int unsigned CROSS_W  = 67;
  localparam int unsigned REST_W   = 69;
  localparam int unsigned NUM_W    = 102;
  localparam int unsigned HI_SHIFT = 34;
  localparam int unsigned MAG_W    = 41;
  localparam int unsigned QUO_W    = 42;
  localparam int unsigned SUM_W    = 43;
  localparam int unsigned DIV_CNT_W = 7;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_TEST,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

@@ src/thq_if.sv @@
// thq_if: input and result channel interfaces
interface thq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            kind;
  logic signed [thq_pkg::COORD_W-1:0]    pos_x;
  logic signed [thq_pkg::COORD_W-1:0]    pos_y;
  logic signed [thq_pkg::COORD_W-1:0]    pos_z;
  logic                                  last_vertex;
  modport source (output valid, kind, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

interface thq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [thq_pkg::COORD_W-1:0]    height;
  logic                                  found;
  modport source (output valid, height, found, input ready);
  modport sink (input valid, height, found, output ready);
endinterface

@@ src/thq_vcell.sv @@
// thq_vcell: one vertex cell of the triangle shift chain
module thq_vcell (
  input  logic               clk_i,
  input  logic               shift_i,
  input  thq_pkg::vtx_t      d_i,
  output thq_pkg::vtx_t      q_o
);
  thq_pkg::vtx_t vtx_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vtx_q <= d_i;
    end
  end

  assign q_o = vtx_q;
endmodule

@@ src/thq_div.sv @@
// thq_div: bit-serial rounding divider with magnitude clamp
module thq_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  thq_pkg::div_ctl_t                    ctl_i,
  input  logic signed [thq_pkg::NUM_W-1:0]     num_i,
  input  logic signed [thq_pkg::CROSS_W-1:0]   den_i,
  output logic                                 done_o,
  output logic signed [thq_pkg::QUO_W-1:0]     quo_o
);
  localparam int unsigned NW = thq_pkg::NUM_W;
  localparam int unsigned DW = thq_pkg::CROSS_W;
  localparam logic [NW-1:0] QClamp = NW'(64'd1 << (thq_pkg::MAG_W - 1));

  logic [NW-1:0]               n_q;
  logic [NW-1:0]               q_q;
  logic [DW-1:0]               du_q;
  logic [DW-1:0]               rem_q;
  logic                        neg_q;
  logic                        busy_q;
  logic                        done_q;
  logic [thq_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [DW:0]                 r2;
  logic                        rnd;
  logic [NW-1:0]               qr;
  logic [thq_pkg::MAG_W-1:0]   mag;

  assign r2 = {rem_q, n_q[NW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= thq_pkg::DIV_CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == thq_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      n_q   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      du_q  <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_q <= num_i[NW-1] ^ den_i[DW-1];
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[NW-2:0], 1'b0};
      if (r2 >= {1'b0, du_q}) begin
        rem_q <= DW'(r2 - {1'b0, du_q});
        q_q   <= {q_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= DW'(r2);
        q_q   <= {q_q[NW-2:0], 1'b0};
      end
    end
  end

  // round half away from zero, then clamp the magnitude
  always_comb begin
    rnd = ({rem_q, 1'b0} >= {1'b0, du_q});
    qr  = q_q + NW'(rnd);
    mag = (qr > QClamp) ? thq_pkg::MAG_W'(QClamp) : thq_pkg::MAG_W'(qr);
    quo_o = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == thq_pkg::DIV_CNT_W'(1)) |=> done_q)
    else $error("divider missed its done pulse");
endmodule

@@ src/terrain_height_query_core.sv @@
// terrain_height_query_core: triangle store and height query top level
//
//  channel  dir  interface    payload
//  in_i     in   thq_in_if    kind, pos_x, pos_y, pos_z, last_vertex
//  out_o    out  thq_out_if   height, found
//
//  query: each stored triangle tried is read into the vertex chain, run through
//    the one shared 35x35 multiplier and tested; the hit adds four partial
//    products and a 102-step serial divide
//  reset clears the vertex count and seal; vertex memory is not cleared
//  a result waits in the output register while the next item is taken
module terrain_height_query_core #(
  parameter int unsigned MaxTriangles = thq_pkg::DEF_MAX_TRIANGLES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  thq_in_if.sink      in_i,
  thq_out_if.source   out_o
);
  localparam int unsigned Depth = 3 * MaxTriangles;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned CW    = thq_pkg::CROSS_W;
  localparam int unsigned MW    = thq_pkg::MUL_W;
  localparam int unsigned NW    = thq_pkg::NUM_W;
  localparam int unsigned SW    = thq_pkg::SUM_W;
  localparam int unsigned RW    = thq_pkg::REST_W;
  localparam int unsigned DFW   = thq_pkg::DIFF_W;
  localparam int unsigned XW    = thq_pkg::COORD_W;

  thq_pkg::state_e state_q, state_d;

  thq_pkg::vtx_t mem [Depth];
  thq_pkg::vtx_t rdata_q;
  thq_pkg::vtx_t chain [4];

  logic [CntW-1:0]          vcnt_q;
  logic                     sealed_q;
  logic [CntW:0]            base_q;
  logic [1:0]               rd_k_q;
  logic                     shift_q;
  logic [2:0]               step_q;
  logic signed [XW-1:0]     px_q, pz_q;
  logic signed [CW-1:0]     c_q, a_q, b_q;
  logic signed [NW-1:0]     num_q;
  logic signed [thq_pkg::PROD_W-1:0] prod_q;
  logic signed [XW-1:0]     res_h_q, out_h_q;
  logic                     res_f_q, out_f_q, out_valid_q;

  logic                     in_xfer, out_xfer, do_load, wr_en, rd_en, out_load;
  logic [AddrW-1:0]         rd_addr;
  logic signed [DFW-1:0]    e1x, e1z, e2x, e2z, dpx, dpz, dy1, dy2;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [RW-1:0]     rest;
  logic                     sc, hit;
  logic [CntW:0]            nxt_base;
  logic                     more_tri;
  thq_pkg::div_ctl_t        div_ctl;
  logic signed [thq_pkg::QUO_W-1:0] quo;
  logic signed [SW-1:0]     hsum;
  logic signed [XW-1:0]     hsat;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;
  assign in_i.ready = (state_q == thq_pkg::ST_IDLE);
  assign do_load  = in_xfer && (in_i.kind == thq_pkg::KIND_LOAD) && !sealed_q;
  assign wr_en    = do_load && (vcnt_q < CntW'(Depth));
  assign rd_en    = (state_q == thq_pkg::ST_READ) && (rd_k_q != 2'd3);
  assign rd_addr  = AddrW'(base_q + (CntW + 1)'(rd_k_q));

  // vertex memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[vcnt_q[AddrW-1:0]] <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // vertex chain: v2 in the first cell, v0 in the last
  assign chain[0] = rdata_q;
  for (genvar g = 0; g < 3; g++) begin : g_cell
    thq_vcell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_q),
      .d_i     (chain[g]),
      .q_o     (chain[g+1])
    );
  end

  assign e1x = DFW'(chain[2].x) - DFW'(chain[3].x);
  assign e1z = DFW'(chain[2].z) - DFW'(chain[3].z);
  assign e2x = DFW'(chain[1].x) - DFW'(chain[3].x);
  assign e2z = DFW'(chain[1].z) - DFW'(chain[3].z);
  assign dpx = DFW'(px_q) - DFW'(chain[3].x);
  assign dpz = DFW'(pz_q) - DFW'(chain[3].z);
  assign dy1 = DFW'(chain[2].y) - DFW'(chain[3].y);
  assign dy2 = DFW'(chain[1].y) - DFW'(chain[3].y);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == thq_pkg::ST_MUL) begin
      case (step_q)
        3'd0: begin mul_a = MW'(e1x); mul_b = MW'(e2z); end
        3'd1: begin mul_a = MW'(e1z); mul_b = MW'(e2x); end
        3'd2: begin mul_a = MW'(dpx); mul_b = MW'(e2z); end
        3'd3: begin mul_a = MW'(dpz); mul_b = MW'(e2x); end
        3'd4: begin mul_a = MW'(e1x); mul_b = MW'(dpz); end
        3'd5: begin mul_a = MW'(e1z); mul_b = MW'(dpx); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == thq_pkg::ST_NUM) begin
      case (step_q)
        3'd0: begin mul_a = $signed({1'b0, a_q[thq_pkg::HI_SHIFT-1:0]}); mul_b = MW'(dy1); end
        3'd1: begin mul_a = MW'($signed(a_q[CW-1:thq_pkg::HI_SHIFT])); mul_b = MW'(dy1); end
        3'd2: begin mul_a = $signed({1'b0, b_q[thq_pkg::HI_SHIFT-1:0]}); mul_b = MW'(dy2); end
        3'd3: begin mul_a = MW'($signed(b_q[CW-1:thq_pkg::HI_SHIFT])); mul_b = MW'(dy2); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // containment test
  always_comb begin
    sc   = c_q[CW-1];
    rest = RW'(c_q) - RW'(a_q) - RW'(b_q);
    hit  = (c_q != '0)
        && ((rest == '0) || (rest[RW-1] == sc))
        && ((a_q == '0) || (a_q[CW-1] == sc))
        && ((b_q == '0) || (b_q[CW-1] == sc));
    nxt_base = base_q + (CntW + 1)'(3);
    more_tri = (nxt_base + (CntW + 1)'(3)) <= (CntW + 1)'(vcnt_q);
  end

  assign div_ctl.start = (state_q == thq_pkg::ST_NUM) && (step_q == 3'd5);

  thq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (num_q),
    .den_i  (c_q),
    .done_o (div_ctl.done),
    .quo_o  (quo)
  );

  always_comb begin
    hsum = SW'(chain[3].y) + SW'(quo);
    if (hsum > SW'(32'sh7fffffff)) begin
      hsat = 32'sh7fffffff;
    end else if (hsum < -SW'(33'sh080000000)) begin
      hsat = 32'sh80000000;
    end else begin
      hsat = XW'(hsum);
    end
  end

  assign out_load = (state_q == thq_pkg::ST_OUT) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      thq_pkg::ST_IDLE: begin
        if (in_xfer && in_i.kind == thq_pkg::KIND_QUERY) begin
          state_d = (vcnt_q >= CntW'(3)) ? thq_pkg::ST_READ : thq_pkg::ST_OUT;
        end
      end
      thq_pkg::ST_READ: if (rd_k_q == 2'd3) state_d = thq_pkg::ST_MUL;
      thq_pkg::ST_MUL:  if (step_q == 3'd6) state_d = thq_pkg::ST_TEST;
      thq_pkg::ST_TEST: begin
        if (hit) begin
          state_d = thq_pkg::ST_NUM;
        end else begin
          state_d = more_tri ? thq_pkg::ST_READ : thq_pkg::ST_OUT;
        end
      end
      thq_pkg::ST_NUM:  if (step_q == 3'd5) state_d = thq_pkg::ST_DIV;
      thq_pkg::ST_DIV:  if (div_ctl.done) state_d = thq_pkg::ST_OUT;
      thq_pkg::ST_OUT:  if (out_load) state_d = thq_pkg::ST_IDLE;
      default:          state_d = thq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= thq_pkg::ST_IDLE;
      vcnt_q      <= '0;
      sealed_q    <= 1'b0;
      base_q      <= '0;
      rd_k_q      <= '0;
      shift_q     <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= rd_en;
      if (do_load) begin
        if (wr_en) vcnt_q <= vcnt_q + 1'b1;
        if (in_i.last_vertex) sealed_q <= 1'b1;
      end
      if (in_xfer && in_i.kind == thq_pkg::KIND_CLEAR) begin
        vcnt_q   <= '0;
        sealed_q <= 1'b0;
      end
      if (in_xfer && in_i.kind == thq_pkg::KIND_QUERY) begin
        base_q <= '0;
        rd_k_q <= '0;
      end
      if (state_q == thq_pkg::ST_READ) begin
        rd_k_q <= rd_k_q + 1'b1;
        step_q <= '0;
      end
      if (state_q == thq_pkg::ST_MUL) step_q <= step_q + 1'b1;
      if (state_q == thq_pkg::ST_NUM) step_q <= step_q + 1'b1;
      if (state_q == thq_pkg::ST_TEST) begin
        step_q <= '0;
        rd_k_q <= '0;
        if (!hit) base_q <= nxt_base;
      end
      if (out_xfer) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_xfer && in_i.kind == thq_pkg::KIND_QUERY) begin
      px_q    <= in_i.pos_x;
      pz_q    <= in_i.pos_z;
      res_h_q <= '0;
      res_f_q <= 1'b0;
    end
    if (state_q == thq_pkg::ST_MUL) begin
      case (step_q)
        3'd1: c_q <= CW'(prod_q);
        3'd2: c_q <= c_q - CW'(prod_q);
        3'd3: a_q <= CW'(prod_q);
        3'd4: a_q <= a_q - CW'(prod_q);
        3'd5: b_q <= CW'(prod_q);
        3'd6: b_q <= b_q - CW'(prod_q);
        default: ;
      endcase
    end
    if (state_q == thq_pkg::ST_TEST) num_q <= '0;
    if (state_q == thq_pkg::ST_NUM) begin
      case (step_q)
        3'd1, 3'd3: num_q <= num_q + NW'(prod_q);
        3'd2, 3'd4: num_q <= num_q + (NW'(prod_q) <<< thq_pkg::HI_SHIFT);
        default: ;
      endcase
    end
    if (state_q == thq_pkg::ST_DIV && div_ctl.done) begin
      res_h_q <= hsat;
      res_f_q <= 1'b1;
    end
    if (out_load) begin
      out_h_q <= res_h_q;
      out_f_q <= res_f_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.height = out_h_q;
  assign out_o.found  = out_f_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= CntW'(Depth))
    else $error("vertex count beyond store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == thq_pkg::ST_READ) |-> (base_q + (CntW + 1)'(3) <= (CntW + 1)'(vcnt_q)))
    else $error("triangle read past the stored vertices");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.kind == thq_pkg::KIND_LOAD && sealed_q) |=> $stable(vcnt_q))
    else $error("load changed a sealed store");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> (state_q == thq_pkg::ST_DIV))
    else $error("divide finished outside its state");
endmodule
